[design/pvc_pkg.sv]
// Package for the pressure varispeed crossfader: field widths, register
// codes, reset values and crossfade weight constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pvc_pkg;

    // Word field widths
    localparam int PRESS_W  = 24;
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 24;
    localparam int FRAC_W   = 16;
    localparam int POS_W    = INDEX_W + FRAC_W;
    localparam int LEN_W    = INDEX_W + 1;
    localparam int AMP_W    = 17;
    localparam int DEAD_W   = 16;

    localparam int S_DATA_W = 120;  // 24 + 6*16
    localparam int M_DATA_W = 80;   // 16 + 16 + 24 + 17, padded to bytes

    // Shared divider: dividend d * 2^16 with d <= divisor, 17 quotient bits
    localparam int DIV_W  = 25;
    localparam int REM_W  = DIV_W + 1;
    localparam int QUO_W  = AMP_W;
    localparam int CNT_W  = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    // Crossfade: weights over 2^17, products and sums
    localparam int A3_W   = 19;
    localparam int A6_W   = 20;
    localparam int WGT_W  = 19;     // signed carrier of an 18-bit weight
    localparam int ACC_W  = WGT_W + SAMPLE_W;
    localparam int QR_W   = ACC_W - 17;

    localparam logic [AMP_W-1:0] AMP_ONE   = 17'd65536;
    localparam logic [A3_W-1:0]  A3_THIRD  = 19'd65536;
    localparam logic [A3_W-1:0]  A3_TWO3   = 19'd131072;
    localparam logic [A6_W-1:0]  W_FULL    = 20'd131072;
    localparam logic [A6_W-1:0]  W_TWO     = 20'd262144;
    localparam logic [A6_W-1:0]  W_THREE   = 20'd393216;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 35'sd65536;
    localparam logic [DIV_W-1:0] STEP_BASE = 25'd65536;

    // Register reset values
    localparam logic signed [PRESS_W-1:0] FLOOR_RESET = -24'sd20000;
    localparam logic signed [PRESS_W-1:0] CEIL_RESET  = 24'sd800000;
    localparam logic [LEN_W-1:0]          LEN_RESET   = 25'd1048576;
    localparam logic [DEAD_W-1:0]         DEAD_RESET  = 16'd983;

    // Register map, word index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_FLOOR = 2'd0,
        REG_CEIL  = 2'd1,
        REG_LEN   = 2'd2,
        REG_DEAD  = 2'd3
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_PREP      = 8'b0000_0010,
        S_DIV_AMP   = 8'b0000_0100,
        S_STEP_LOAD = 8'b0000_1000,
        S_DIV_STEP  = 8'b0001_0000,
        S_POS       = 8'b0010_0000,
        S_MAC       = 8'b0100_0000,
        S_WB        = 8'b1000_0000
    } state_t;

endpackage : pvc_pkg

`default_nettype wire

[design/pressure_varispeed_crossfader_unit.sv]
// Top level of the pressure varispeed crossfader: sequencer, shared
// restoring divider, shared multiplier, position register, APB registers.
// Depends on pvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+----------------------------------
//  s_ words  | in  | s_tvalid / s_tready     | s_tdata: pressure, 6 track samples
//  m_ words  | out | m_tvalid / m_tready     | m_tdata: mix L/R, fetch index, level
//  APB       | in  | psel, penable, pready=1 | paddr[3:2] picks one of 4 registers
//
// One word runs from accept to the next accept through prep, a pass of the one
// restoring divider for the amplitude (skipped when the ceiling is not above
// the floor), a step load, a second pass for the position step, the position
// update, the one multiplier (four crossfade products and the last add),
// writeback and the idle accept.
// The result sits in an output register; the next word is taken while it waits.
// A stall on m_tready holds the sequencer in writeback only if the output
// register is still full. Reset (aresetn low, synchronous) clears the
// sequencer, the output valid, the play position and the registers.

module pressure_varispeed_crossfader_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // pressure[23:0], original_left[39:24], original_right[55:40],
    // remix_left[71:56], remix_right[87:72], full_left[103:88], full_right[119:104]
    input  wire logic [pvc_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // mix_left[15:0], mix_right[31:16], fetch_index[55:32], level[72:56], zero[79:73]
    output logic [pvc_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import pvc_pkg::*;

    // ---------------- registers ----------------
    state_t state_reg, state_next;

    logic signed [PRESS_W-1:0] floor_reg, ceil_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [DEAD_W-1:0]         dead_reg;

    logic [POS_W-1:0]          pos_reg;

    // latched word
    logic signed [PRESS_W-1:0]  p_reg;
    logic signed [SAMPLE_W-1:0] ol_reg, or_reg, rl_reg, rr_reg, fl_reg, fr_reg;

    // shared divider
    logic [REM_W-1:0] rem_reg;
    logic [DIV_W-1:0] div_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [AMP_W-1:0] amp_reg;

    // shared multiplier
    logic [2:0]              mac_reg;
    logic signed [ACC_W-1:0] prod_reg, acc_l_reg, acc_r_reg;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]  m_mixl_reg, m_mixr_reg;
    logic [INDEX_W-1:0]   m_idx_reg;
    logic [AMP_W-1:0]     m_lvl_reg;

    // ---------------- APB ----------------
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= FLOOR_RESET;
            ceil_reg  <= CEIL_RESET;
            len_reg   <= LEN_RESET;
            dead_reg  <= DEAD_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FLOOR: floor_reg <= pwdata[PRESS_W-1:0];
                REG_CEIL:  ceil_reg  <= pwdata[PRESS_W-1:0];
                REG_LEN:   len_reg   <= pwdata[LEN_W-1:0];
                REG_DEAD:  dead_reg  <= pwdata[DEAD_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FLOOR: prdata = {{(32-PRESS_W){floor_reg[PRESS_W-1]}}, floor_reg};
            REG_CEIL:  prdata = {{(32-PRESS_W){ceil_reg[PRESS_W-1]}}, ceil_reg};
            REG_LEN:   prdata = {{(32-LEN_W){1'b0}}, len_reg};
            REG_DEAD:  prdata = {{(32-DEAD_W){1'b0}}, dead_reg};
            default:   prdata = '0;
        endcase
    end

    // ---------------- prep: clamp and offset ----------------
    logic                      degen;
    logic signed [PRESS_W-1:0] clamped;
    logic [DIV_W-1:0]          num_d, den_d;

    assign degen = (ceil_reg <= floor_reg);

    always_comb begin
        if (p_reg < floor_reg)
            clamped = floor_reg;
        else if (p_reg > ceil_reg)
            clamped = ceil_reg;
        else
            clamped = p_reg;
    end

    assign num_d = {clamped[PRESS_W-1], clamped} - {floor_reg[PRESS_W-1], floor_reg};
    assign den_d = {ceil_reg[PRESS_W-1], ceil_reg} - {floor_reg[PRESS_W-1], floor_reg};

    // ---------------- divider step ----------------
    logic [REM_W:0]   rem_diff;
    logic             rem_ge;
    logic [REM_W-1:0] rem_step;
    logic [QUO_W-1:0] quo_step;

    assign rem_diff = {1'b0, rem_reg} - {2'b00, div_reg};
    assign rem_ge   = ~rem_diff[REM_W];
    assign rem_step = (rem_ge ? rem_diff[REM_W-1:0] : rem_reg) << 1;
    assign quo_step = {quo_reg[QUO_W-2:0], rem_ge};

    // ---------------- crossfade weights ----------------
    logic [A3_W-1:0] a3;
    logic [A6_W-1:0] a6, w1, w2;
    logic            reg_lo, reg_mid;

    assign a3      = {2'b00, amp_reg} + {1'b0, amp_reg, 1'b0};
    assign a6      = {a3, 1'b0};
    assign reg_lo  = (a3 < A3_THIRD);
    assign reg_mid = (a3 < A3_TWO3);

    always_comb begin
        if (reg_lo) begin
            w1 = {1'b0, a3};
            w2 = '0;
        end else if (reg_mid) begin
            w1 = a6 - W_FULL;
            w2 = W_FULL - {1'b0, a3};
        end else begin
            w1 = W_THREE - a6;
            w2 = a6 - W_TWO;
        end
    end

    // first term: original in the low third, remix above; second: original below the top third, full on top
    logic signed [WGT_W-1:0]    mul_w;
    logic signed [SAMPLE_W-1:0] mul_x;
    logic signed [ACC_W-1:0]    mul_out;

    always_comb begin
        case (mac_reg[1:0])
            2'd0: begin
                mul_w = {1'b0, w1[WGT_W-2:0]};
                mul_x = reg_lo ? ol_reg : rl_reg;
            end
            2'd1: begin
                mul_w = {1'b0, w2[WGT_W-2:0]};
                mul_x = (reg_lo || reg_mid) ? ol_reg : fl_reg;
            end
            2'd2: begin
                mul_w = {1'b0, w1[WGT_W-2:0]};
                mul_x = reg_lo ? or_reg : rr_reg;
            end
            default: begin
                mul_w = {1'b0, w2[WGT_W-2:0]};
                mul_x = (reg_lo || reg_mid) ? or_reg : fr_reg;
            end
        endcase
    end

    assign mul_out = mul_w * mul_x;

    // ---------------- position update ----------------
    logic [POS_W-1:0] pos_sum;
    logic             pos_wrap;

    assign pos_sum  = pos_reg + {{(POS_W-QUO_W){1'b0}}, quo_reg};
    assign pos_wrap = ({1'b0, pos_sum[POS_W-1:FRAC_W]} >= len_reg);

    // ---------------- rounding, saturation, deadzone ----------------
    function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] biased;
        logic signed [QR_W-1:0]  q;
        biased = acc + ROUND_HALF;
        q      = biased[ACC_W-1:ACC_W-QR_W];
        if (q > QR_W'(32767))
            round_sat = 16'h7FFF;
        else if (q < -QR_W'(32768))
            round_sat = 16'h8000;
        else
            round_sat = q[SAMPLE_W-1:0];
    endfunction

    logic                mute;
    logic [SAMPLE_W-1:0] mix_l, mix_r;
    logic                wb_load;

    assign mute    = (amp_reg < {1'b0, dead_reg});
    assign mix_l   = mute ? '0 : round_sat(acc_l_reg);
    assign mix_r   = mute ? '0 : round_sat(acc_r_reg);
    assign wb_load = (state_reg == S_WB) && (!m_valid_reg || m_tready);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_PREP;
            S_PREP:      state_next = degen ? S_STEP_LOAD : S_DIV_AMP;
            S_DIV_AMP:   if (cnt_reg == DIV_LAST) state_next = S_STEP_LOAD;
            S_STEP_LOAD: state_next = S_DIV_STEP;
            S_DIV_STEP:  if (cnt_reg == DIV_LAST) state_next = S_POS;
            S_POS:       state_next = S_MAC;
            S_MAC:       if (mac_reg == 3'd4) state_next = S_WB;
            S_WB:        if (wb_load) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_POS)
                pos_reg <= pos_wrap ? '0 : pos_sum;
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            p_reg  <= s_tdata[23:0];
            ol_reg <= s_tdata[39:24];
            or_reg <= s_tdata[55:40];
            rl_reg <= s_tdata[71:56];
            rr_reg <= s_tdata[87:72];
            fl_reg <= s_tdata[103:88];
            fr_reg <= s_tdata[119:104];
        end

        case (state_reg)
            S_PREP: begin
                rem_reg <= {1'b0, num_d};
                div_reg <= den_d;
                cnt_reg <= '0;
                if (degen)
                    amp_reg <= (p_reg >= ceil_reg) ? AMP_ONE : '0;
            end
            S_DIV_AMP, S_DIV_STEP: begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                cnt_reg <= cnt_reg + 1'b1;
                if (state_reg == S_DIV_AMP && cnt_reg == DIV_LAST)
                    amp_reg <= quo_step;
            end
            S_STEP_LOAD: begin
                // step = 2^32 / (65536 + 3A)
                rem_reg <= {1'b0, STEP_BASE};
                div_reg <= STEP_BASE + {{(DIV_W-A3_W){1'b0}}, a3};
                cnt_reg <= '0;
            end
            S_POS: begin
                mac_reg <= '0;
            end
            S_MAC: begin
                mac_reg  <= mac_reg + 1'b1;
                prod_reg <= mul_out;
                case (mac_reg)
                    3'd1:    acc_l_reg <= prod_reg;
                    3'd2:    acc_l_reg <= acc_l_reg + prod_reg;
                    3'd3:    acc_r_reg <= prod_reg;
                    3'd4:    acc_r_reg <= acc_r_reg + prod_reg;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (wb_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (wb_load) begin
            m_mixl_reg <= mix_l;
            m_mixr_reg <= mix_r;
            m_idx_reg  <= pos_reg[POS_W-1:FRAC_W];
            m_lvl_reg  <= amp_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-73){1'b0}}, m_lvl_reg, m_idx_reg, m_mixr_reg, m_mixl_reg};

`ifndef SYNTHESIS
    // accepted word always starts the prep step
    a_accept_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_PREP))
        else $error("accepted word did not enter prep");

    // amplitude never exceeds one at writeback
    a_amp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WB) |-> (amp_reg <= AMP_ONE))
        else $error("amplitude out of range");

    // restoring divider keeps its partial remainder below twice the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DIV_AMP) || (state_reg == S_DIV_STEP)) |->
            (rem_reg < {div_reg, 1'b0}))
        else $error("divider remainder out of bound");

    // reported index lies inside the track or is the wrapped zero
    a_index_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (({1'b0, m_idx_reg} < len_reg) || (m_idx_reg == '0)))
        else $error("fetch index beyond track length");
`endif

endmodule : pressure_varispeed_crossfader_unit

`default_nettype wire
